@@ rtl/core/fts_pkg.sv @@
// Shared constants and codes of the FIFO task scheduler with sleepers.
package fts_pkg;

	// Default sizing
	localparam int TASKS_DEF = 64;
	localparam int CPUS_DEF  = 8;

	// Field widths of the request and result items
	localparam int FUNC_W   = 3;
	localparam int CPU_W    = 3;
	localparam int TID_W    = 6;
	localparam int NOW_W    = 64;
	localparam int DUR_W    = 32;
	localparam int STAT_W   = 3;
	localparam int WOKEN_W  = 7;
	localparam int S_DATA_W = 112;
	localparam int M_DATA_W = 24;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_CREATE = 3'd0;
	localparam logic [FUNC_W-1:0] FN_START  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SLEEP  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_WAKE   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SCHED  = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DONE     = 3'd0;
	localparam logic [STAT_W-1:0] ST_NOOP     = 3'd1;
	localparam logic [STAT_W-1:0] ST_BUSY     = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_CPU   = 3'd3;
	localparam logic [STAT_W-1:0] ST_DISABLED = 3'd4;

endpackage

@@ rtl/core/fifo_task_scheduler_with_sleepers.sv @@
// Top level of the FIFO task scheduler with sleepers.
//
// One request at a time is taken and answered with one result. Create, start,
// sleep and unknown operations go from accept through execute to the result
// state; schedule releases the cpu's task, then reads and pops the ready ring,
// skipping the pop when the ring is empty and both when the cpu is not started.
// Wake adds a read and an evaluate state per sleeper, since each node needs a
// read of the sleep-link and wake-time memories before the shared 64-bit adder
// decides whether it is due. The same adder forms the saturating wake time on
// sleep. s_tready is high while no request is in work; a finished result waits
// in the output register without blocking the next request. No clearing pass.
module fifo_task_scheduler_with_sleepers #(
	parameter int TASKS = fts_pkg::TASKS_DEF,
	parameter int CPUS  = fts_pkg::CPUS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// func[2:0], cpu[5:3], task_id[11:6], now_ticks[75:12], sleep_duration[107:76]
	input  logic [fts_pkg::S_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status[2:0], chosen_task[8:3], runs_idle[9], woken_count[16:10]
	output logic [fts_pkg::M_DATA_W-1:0]  m_tdata
);
	import fts_pkg::*;

	localparam int TIW  = $clog2(TASKS);
	localparam int CW   = $clog2(TASKS + 2);
	localparam int CNTW = $clog2(TASKS + 1);
	localparam int CPW  = (CPUS > 1) ? $clog2(CPUS) : 1;
	localparam logic [CW-1:0] IDLE_C = CW'(TASKS);
	localparam logic [CW-1:0] OFF_C  = CW'(TASKS + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_WRD, S_WEV, S_SRD, S_SPOP, S_RESP
	} state_t;

	state_t               state_q;
	logic                 enable_q;
	logic [FUNC_W-1:0]    func_q;
	logic [CPU_W-1:0]     cpu_q;
	logic [TID_W-1:0]     tid_q;
	logic [NOW_W-1:0]     now_q;
	logic [DUR_W-1:0]     dur_q;
	logic [TASKS-1:0]     used_q, asleep_q, queued_q, running_q;
	logic [CW-1:0]        cpu_task_q [CPUS];
	logic [TIW-1:0]       head_q;
	logic [CNTW-1:0]      count_q;
	logic [CW-1:0]        top_q;
	logic [CW-1:0]        cur_q;
	logic [TIW-1:0]       prev_q;
	logic                 prev_v_q;
	logic [CNTW-1:0]      woken_q;
	logic [STAT_W-1:0]    stat_q;
	logic [TIW-1:0]       chosen_q;
	logic                 idle_q;
	logic [M_DATA_W-1:0]  out_q;
	logic                 out_v_q;

	// Decoded request
	logic                 cpu_ok, tid_ok, worker_ok, worker_on, sleep_ok;
	logic [CPW-1:0]       cpu_idx;
	logic [TIW-1:0]       tid_idx, worker_idx, cur_idx;
	logic [CW-1:0]        worker;

	// Shared adder
	logic [NOW_W-1:0]     add_b, add_sum;
	logic                 add_cin, add_co;
	logic [NOW_W-1:0]     wake_at;

	// Memory ports
	logic                 wt_we, link_we, ring_we;
	logic [TIW-1:0]       link_waddr, ring_waddr, ring_raddr;
	logic [CW-1:0]        link_wdata, link_rdata;
	logic [NOW_W-1:0]     wt_rdata;
	logic [TIW-1:0]       ring_rdata;

	// Ready-ring push
	logic                 push_req, push_ok;
	logic [TIW-1:0]       push_t;
	logic [TIW:0]         tail_sum;
	logic [TIW-1:0]       tail;
	logic [TIW:0]         head_inc;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	assign cpu_ok     = 32'(cpu_q) < CPUS;
	assign cpu_idx    = CPW'(cpu_q);
	assign tid_ok     = 32'(tid_q) < TASKS;
	assign tid_idx    = TIW'(tid_q);
	assign worker     = cpu_task_q[cpu_idx];
	assign worker_on  = cpu_ok && (worker <= IDLE_C);
	assign worker_ok  = 32'(worker) < TASKS;
	assign worker_idx = worker[TIW-1:0];
	assign cur_idx    = cur_q[TIW-1:0];
	assign sleep_ok   = (dur_q != '0) && worker_on && worker_ok && !asleep_q[worker_idx];

	// Add now and duration on sleep; compare now against wake time on wake
	assign add_b   = (state_q == S_WEV) ? ~wt_rdata : {{(NOW_W - DUR_W){1'b0}}, dur_q};
	assign add_cin = (state_q == S_WEV);
	assign {add_co, add_sum} = {1'b0, now_q} + {1'b0, add_b} + (NOW_W + 1)'(add_cin);
	assign wake_at = add_co ? {NOW_W{1'b1}} : add_sum;

	// Ring tail and head advance
	assign tail_sum = {1'b0, head_q} + (TIW + 1)'(count_q);
	assign tail     = (32'(tail_sum) >= TASKS) ? TIW'(32'(tail_sum) - TASKS) : tail_sum[TIW-1:0];
	assign head_inc = {1'b0, head_q} + (TIW + 1)'(1);
	assign push_ok  = push_req && !queued_q[push_t] && (32'(count_q) < TASKS);

	// Drive memory ports and push requests per state
	always_comb begin
		push_req   = 1'b0;
		push_t     = '0;
		wt_we      = 1'b0;
		link_we    = 1'b0;
		link_waddr = worker_idx;
		link_wdata = top_q;
		ring_raddr = head_q;
		unique case (state_q)
			S_EXEC: begin
				if (enable_q) begin
					case (func_q) inside
						FN_CREATE: begin
							push_req = tid_ok && !used_q[tid_idx];
							push_t   = tid_idx;
						end
						FN_START, FN_SCHED: begin
							push_req = worker_on && worker_ok && !asleep_q[worker_idx];
							push_t   = worker_idx;
						end
						FN_SLEEP: begin
							wt_we   = sleep_ok;
							link_we = sleep_ok;
						end
						default: begin
						end
					endcase
				end
			end
			S_WEV: begin
				if (add_co) begin
					link_we    = prev_v_q;
					link_waddr = prev_q;
					link_wdata = link_rdata;
					push_req   = !running_q[cur_idx];
					push_t     = cur_idx;
				end
			end
			default: begin
			end
		endcase
		ring_we    = push_ok;
		ring_waddr = tail;
	end

	fts_ram #(.WIDTH(NOW_W), .DEPTH(TASKS)) u_wake_time (
		.clk   (clk),
		.we    (wt_we),
		.waddr (worker_idx),
		.wdata (wake_at),
		.raddr (cur_idx),
		.rdata (wt_rdata)
	);

	fts_ram #(.WIDTH(CW), .DEPTH(TASKS)) u_sleep_link (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (cur_idx),
		.rdata (link_rdata)
	);

	fts_ram #(.WIDTH(TIW), .DEPTH(TASKS)) u_ready_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (push_t),
		.raddr (ring_raddr),
		.rdata (ring_rdata)
	);

	// Sequencer, scheduler state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			enable_q  <= 1'b0;
			used_q    <= '0;
			asleep_q  <= '0;
			queued_q  <= '0;
			running_q <= '0;
			head_q    <= '0;
			count_q   <= '0;
			top_q     <= IDLE_C;
			for (int i = 0; i < CPUS; i++) begin
				cpu_task_q[i] <= OFF_C;
			end
			out_v_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			if (out_v_q && m_tready && (state_q != S_RESP)) begin
				out_v_q <= 1'b0;
			end
			// Append to the ready ring
			if (push_ok) begin
				queued_q[push_t] <= 1'b1;
				count_q          <= count_q + CNTW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q   <= s_tdata[2:0];
						cpu_q    <= s_tdata[5:3];
						tid_q    <= s_tdata[11:6];
						now_q    <= s_tdata[75:12];
						dur_q    <= s_tdata[107:76];
						stat_q   <= ST_DONE;
						chosen_q <= '0;
						idle_q   <= 1'b0;
						woken_q  <= '0;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					if (!enable_q) begin
						stat_q <= ST_DISABLED;
					end else begin
						case (func_q)
							FN_CREATE: begin
								if (!tid_ok) begin
									stat_q <= ST_NOOP;
								end else if (used_q[tid_idx]) begin
									stat_q <= ST_BUSY;
								end else begin
									used_q[tid_idx]    <= 1'b1;
									asleep_q[tid_idx]  <= 1'b0;
									running_q[tid_idx] <= 1'b0;
									chosen_q           <= tid_idx;
								end
							end
							FN_START: begin
								if (!cpu_ok) begin
									stat_q <= ST_NOOP;
								end else begin
									if (worker_on && worker_ok) begin
										running_q[worker_idx] <= 1'b0;
									end
									cpu_task_q[cpu_idx] <= IDLE_C;
									idle_q              <= 1'b1;
								end
							end
							FN_SLEEP: begin
								if (dur_q == '0) begin
									stat_q <= ST_NOOP;
								end else if (!worker_on) begin
									stat_q <= ST_NO_CPU;
								end else if (!worker_ok) begin
									stat_q <= ST_NOOP;
								end else if (asleep_q[worker_idx]) begin
									stat_q <= ST_BUSY;
								end else begin
									asleep_q[worker_idx] <= 1'b1;
									top_q                <= worker;
									chosen_q             <= worker_idx;
								end
							end
							FN_WAKE: begin
								cur_q    <= top_q;
								prev_v_q <= 1'b0;
								if (32'(top_q) < TASKS) begin
									state_q <= S_WRD;
								end
							end
							FN_SCHED: begin
								if (!worker_on) begin
									stat_q <= ST_NO_CPU;
								end else begin
									if (worker_ok) begin
										running_q[worker_idx] <= 1'b0;
									end
									state_q <= S_SRD;
								end
							end
							default: begin
								stat_q <= ST_NOOP;
							end
						endcase
					end
				end
				S_WRD: begin
					state_q <= S_WEV;
				end
				S_WEV: begin
					// Unlink a due sleeper, keep the others
					if (add_co) begin
						if (!prev_v_q) begin
							top_q <= link_rdata;
						end
						asleep_q[cur_idx] <= 1'b0;
						woken_q           <= woken_q + CNTW'(1);
					end else begin
						prev_q   <= cur_idx;
						prev_v_q <= 1'b1;
					end
					cur_q   <= link_rdata;
					state_q <= (32'(link_rdata) < TASKS) ? S_WRD : S_RESP;
				end
				S_SRD: begin
					if (count_q == '0) begin
						cpu_task_q[cpu_idx] <= IDLE_C;
						idle_q              <= 1'b1;
						state_q             <= S_RESP;
					end else begin
						state_q <= S_SPOP;
					end
				end
				S_SPOP: begin
					// Pop the ring head onto the cpu
					head_q  <= (32'(head_inc) >= TASKS) ? '0 : head_inc[TIW-1:0];
					count_q <= count_q - CNTW'(1);
					if (32'(ring_rdata) < TASKS) begin
						queued_q[ring_rdata]  <= 1'b0;
						running_q[ring_rdata] <= 1'b1;
						cpu_task_q[cpu_idx]   <= CW'(ring_rdata);
						chosen_q              <= ring_rdata;
					end else begin
						cpu_task_q[cpu_idx] <= IDLE_C;
						idle_q              <= 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// Hand the result over once the output register is free
					if (!out_v_q || m_tready) begin
						out_q   <= {7'b0, WOKEN_W'(woken_q), idle_q,
							TID_W'(chosen_q), stat_q};
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Ring occupancy matches the queued marks
	a_count_marks: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(queued_q) == 32'(count_q)))
		else $error("ready count differs from queued marks");

	// No second request enters while one is in work
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request accepted while busy");

	// A result appears only from the result state
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_RESP))
		else $error("result raised outside result state");

	// Ring never holds more than all tasks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count_q) <= TASKS))
		else $error("ready ring overfilled");

endmodule

@@ rtl/core/fts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
